>>> design/rrhp_pkg.sv
// Shared types and constants for the redundant RTP header parser.
package rrhp_pkg;

  // Field masks and widths
  localparam logic [6:0] TYPE_MASK = 7'h7F;
  localparam logic [1:0] LEN_HIGH_MASK = 2'h3;
  localparam logic [15:0] SUM_MAX = 16'hFFFF;

  // Record kinds
  localparam logic KIND_REDUNDANT = 1'b0;
  localparam logic KIND_PRIMARY = 1'b1;

  // Queue depth between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // One input word
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic [15:0] packet_length;
  } in_t;

  // One result word
  typedef struct packed {
    logic        record_kind;
    logic [6:0]  payload_type;
    logic [13:0] timestamp_offset;
    logic [15:0] block_start;
    logic [15:0] block_length;
    logic [15:0] header_bytes;
    logic        length_error;
  } out_t;

  // Classified record handed from front to back
  typedef struct packed {
    out_t        rec;
    logic        need_size;
    logic [15:0] total_length;
  } job_t;

endpackage

>>> design/rrhp_front.sv
// Front end: per-byte header parse that turns the header bytes into record jobs.
module rrhp_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           byte_valid,
  output logic           byte_ready,
  input  rrhp_pkg::in_t  byte_item,
  output logic           push_valid,
  input  logic           push_ready,
  output rrhp_pkg::job_t push_job
);

  localparam logic [2:0] PH_HDR0 = 3'd0;
  localparam logic [2:0] PH_HDR1 = 3'd1;
  localparam logic [2:0] PH_HDR2 = 3'd2;
  localparam logic [2:0] PH_HDR3 = 3'd3;
  localparam logic [2:0] PH_DONE = 3'd4;

  logic [2:0]  parse_phase, parse_phase_next;
  logic [15:0] header_byte_count, header_byte_count_next;
  logic [15:0] redundant_sum, redundant_sum_next;
  logic [6:0]  held_type, held_type_next;
  logic [13:0] held_offset, held_offset_next;
  logic [1:0]  held_length_high, held_length_high_next;
  logic [15:0] total_length, total_length_next;
  logic [15:0] bytes_seen, bytes_seen_next;

  logic           accept;
  logic           emit;
  rrhp_pkg::job_t job;
  logic [7:0]     b;
  logic [9:0]     blk_len;
  logic [16:0]    sum_wide;

  assign byte_ready = push_ready;
  assign accept = byte_valid && byte_ready;
  assign b = byte_item.data_byte;

  // Compute next parse state and the record this byte raises
  always_comb begin
    parse_phase_next = parse_phase;
    header_byte_count_next = header_byte_count;
    redundant_sum_next = redundant_sum;
    held_type_next = held_type;
    held_offset_next = held_offset;
    held_length_high_next = held_length_high;
    total_length_next = total_length;
    bytes_seen_next = bytes_seen;
    emit = 1'b0;
    job = '0;
    blk_len = {held_length_high, b};
    sum_wide = {1'b0, redundant_sum} + {7'b0, blk_len};

    // Restart on the first byte of a packet
    if (byte_item.first_byte) begin
      total_length_next = byte_item.packet_length;
      bytes_seen_next = '0;
      header_byte_count_next = '0;
      redundant_sum_next = '0;
      held_type_next = '0;
      held_offset_next = '0;
      held_length_high_next = '0;
      parse_phase_next = PH_HDR0;
    end
    sum_wide = {1'b0, redundant_sum_next} + {7'b0, blk_len};

    if (bytes_seen_next < total_length_next && parse_phase_next != PH_DONE) begin
      bytes_seen_next = bytes_seen_next + 16'd1;
      header_byte_count_next = header_byte_count_next + 16'd1;
      unique case (parse_phase_next)
        PH_HDR0: begin
          if (b[7]) begin
            held_type_next = b[6:0] & rrhp_pkg::TYPE_MASK;
            parse_phase_next = PH_HDR1;
          end else begin
            // Primary header: size is settled in the back end
            emit = 1'b1;
            job.rec.record_kind = rrhp_pkg::KIND_PRIMARY;
            job.rec.payload_type = b[6:0] & rrhp_pkg::TYPE_MASK;
            job.rec.block_start = redundant_sum_next;
            job.rec.header_bytes = header_byte_count_next;
            job.need_size = 1'b1;
            job.total_length = total_length_next;
            parse_phase_next = PH_DONE;
          end
        end
        PH_HDR1: begin
          held_offset_next = {b, 6'b0};
          parse_phase_next = PH_HDR2;
        end
        PH_HDR2: begin
          held_offset_next = held_offset_next | {8'b0, b[7:2]};
          held_length_high_next = b[1:0] & rrhp_pkg::LEN_HIGH_MASK;
          parse_phase_next = PH_HDR3;
        end
        PH_HDR3: begin
          // Close one redundant header and saturate the running sum
          redundant_sum_next = sum_wide[16] ? rrhp_pkg::SUM_MAX : sum_wide[15:0];
          parse_phase_next = PH_HDR0;
          if (bytes_seen_next < total_length_next) begin
            emit = 1'b1;
            job.rec.record_kind = rrhp_pkg::KIND_REDUNDANT;
            job.rec.payload_type = held_type_next;
            job.rec.timestamp_offset = held_offset_next;
            job.rec.block_start = redundant_sum;
            job.rec.block_length = {6'b0, blk_len};
            if (byte_item.first_byte) begin
              job.rec.block_start = '0;
            end
          end
        end
        default: begin
          parse_phase_next = PH_DONE;
        end
      endcase

      // Packet ended inside the headers
      if (!emit && parse_phase_next != PH_DONE && bytes_seen_next >= total_length_next) begin
        emit = 1'b1;
        job = '0;
        job.rec.record_kind = rrhp_pkg::KIND_PRIMARY;
        job.rec.block_start = redundant_sum_next;
        job.rec.header_bytes = header_byte_count_next;
        job.rec.length_error = 1'b1;
        parse_phase_next = PH_DONE;
      end
    end
  end

  assign push_valid = accept && emit;
  assign push_job = job;

  // Commit parse state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase <= PH_HDR0;
      header_byte_count <= '0;
      redundant_sum <= '0;
      held_type <= '0;
      held_offset <= '0;
      held_length_high <= '0;
      total_length <= '0;
      bytes_seen <= '0;
    end else if (accept) begin
      parse_phase <= parse_phase_next;
      header_byte_count <= header_byte_count_next;
      redundant_sum <= redundant_sum_next;
      held_type <= held_type_next;
      held_offset <= held_offset_next;
      held_length_high <= held_length_high_next;
      total_length <= total_length_next;
      bytes_seen <= bytes_seen_next;
    end
  end

endmodule

>>> design/rrhp_queue.sv
// Short queue of record jobs between front and back end.
module rrhp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  rrhp_pkg::job_t push_job,
  output logic           pop_valid,
  input  logic           pop_ready,
  output rrhp_pkg::job_t pop_job
);

  rrhp_pkg::job_t mem [rrhp_pkg::QUEUE_DEPTH];
  logic [rrhp_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [rrhp_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [rrhp_pkg::QUEUE_CNT_W-1:0] count;
  logic do_push;
  logic do_pop;

  assign push_ready = count != rrhp_pkg::QUEUE_CNT_W'(rrhp_pkg::QUEUE_DEPTH);
  assign pop_valid = count != '0;
  assign pop_job = mem[rd_ptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == rrhp_pkg::QUEUE_PTR_W'(rrhp_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == rrhp_pkg::QUEUE_PTR_W'(rrhp_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> design/rrhp_back.sv
// Back end: settles the primary size and holds the result word for the consumer.
module rrhp_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  rrhp_pkg::job_t pop_job,
  output logic           rec_valid,
  input  logic           rec_ready,
  output rrhp_pkg::out_t rec_item
);

  rrhp_pkg::out_t rec_next;
  logic [16:0]    used;
  logic           short;

  assign pop_ready = !rec_valid || rec_ready;

  // Primary size: packet length minus headers minus redundant blocks, floored at 0
  always_comb begin
    rec_next = pop_job.rec;
    used = {1'b0, pop_job.rec.header_bytes} + {1'b0, pop_job.rec.block_start};
    short = used > {1'b0, pop_job.total_length};
    if (pop_job.need_size) begin
      rec_next.length_error = short;
      rec_next.block_length = short ? '0 : pop_job.total_length - used[15:0];
    end
  end

  // Hold output word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (pop_ready) begin
      rec_valid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_ready && pop_valid) begin
      rec_item <= rec_next;
    end
  end

endmodule

>>> design/rtp_red_header_parser_top.sv
// Top level of the redundant RTP payload header parser.
// A record is stored in the job queue, then in the output register behind rec_valid.
// Throughput: one byte per cycle while the job queue is not full.
// A two-entry job queue and the output register let either side stall on its own.
// Reset (synchronous, rst high) clears parse state, the queue and the output valid.
module rtp_red_header_parser_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           byte_valid,
  output logic           byte_ready,
  input  rrhp_pkg::in_t  byte_item,
  output logic           rec_valid,
  input  logic           rec_ready,
  output rrhp_pkg::out_t rec_item
);

  logic           push_valid;
  logic           push_ready;
  rrhp_pkg::job_t push_job;
  logic           pop_valid;
  logic           pop_ready;
  rrhp_pkg::job_t pop_job;

  rrhp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_item  (byte_item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  rrhp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  rrhp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .rec_item  (rec_item)
  );

endmodule

>>> test/rtp_red_header_parser_top_test.sv
// Self-checking testbench for the redundant RTP payload header parser.
module rtp_red_header_parser_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Parse phases of the predictor
  typedef enum logic [2:0] {
    AT_LEAD,
    AT_OFFSET_HI,
    AT_OFFSET_LO,
    AT_LENGTH,
    AT_DONE
  } phase_t;

  logic clk;
  logic rst = 1'b1;
  logic byte_valid = 1'b0;
  logic byte_ready;
  rrhp_pkg::in_t byte_item = '0;
  logic rec_valid;
  logic rec_ready = 1'b0;
  rrhp_pkg::out_t rec_item;

  rtp_red_header_parser_top dut (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(byte_valid),
    .byte_ready(byte_ready),
    .byte_item (byte_item),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .rec_item  (rec_item)
  );

  // Predictor state, at its reset values
  phase_t cur_phase = AT_LEAD;
  logic [15:0] hdr_count = '0;
  logic [15:0] red_sum = '0;
  logic [15:0] pkt_total = '0;
  logic [15:0] pkt_seen = '0;
  logic [6:0] hold_type = '0;
  logic [13:0] hold_offset = '0;
  logic [1:0] hold_len_hi = '0;

  rrhp_pkg::out_t pending_records[$];
  logic [7:0] pkt_bytes[$];

  bit idle_on = 1'b1;
  int hold_request = 0;
  int fault_count = 0;
  int bytes_sent = 0;
  int bytes_parsed = 0;
  int redundant_seen = 0;
  int primary_seen = 0;
  int error_seen = 0;

  // Advance the header parse by one byte; report whether it was parsed and its record
  function automatic void parse_byte(input rrhp_pkg::in_t w, output bit parsed,
                                     output bit produced, output rrhp_pkg::out_t rec);
    logic [16:0] used;
    logic [16:0] acc;
    logic [9:0] len;
    logic [15:0] start;
    parsed = 1'b0;
    produced = 1'b0;
    rec = '0;
    if (w.first_byte) begin
      pkt_total = w.packet_length;
      pkt_seen = '0;
      hdr_count = '0;
      red_sum = '0;
      hold_type = '0;
      hold_offset = '0;
      hold_len_hi = '0;
      cur_phase = AT_LEAD;
    end
    if (pkt_seen >= pkt_total || cur_phase == AT_DONE) return;
    parsed = 1'b1;
    pkt_seen++;
    hdr_count++;
    case (cur_phase)
      AT_LEAD: begin
        if (w.data_byte[7]) begin
          hold_type = w.data_byte[6:0];
          cur_phase = AT_OFFSET_HI;
        end else begin
          // Primary header closes the chain
          used = {1'b0, hdr_count} + {1'b0, red_sum};
          rec.record_kind = rrhp_pkg::KIND_PRIMARY;
          rec.payload_type = w.data_byte[6:0];
          rec.block_start = red_sum;
          rec.header_bytes = hdr_count;
          if (used <= {1'b0, pkt_total}) rec.block_length = pkt_total - used[15:0];
          else rec.length_error = 1'b1;
          cur_phase = AT_DONE;
          produced = 1'b1;
          return;
        end
      end
      AT_OFFSET_HI: begin
        hold_offset = {w.data_byte, 6'b0};
        cur_phase = AT_OFFSET_LO;
      end
      AT_OFFSET_LO: begin
        hold_offset = hold_offset | {8'b0, w.data_byte[7:2]};
        hold_len_hi = w.data_byte[1:0];
        cur_phase = AT_LENGTH;
      end
      AT_LENGTH: begin
        // Close one redundant header; saturate the running length sum
        len = {hold_len_hi, w.data_byte};
        start = red_sum;
        acc = {1'b0, red_sum} + {7'b0, len};
        red_sum = acc[16] ? rrhp_pkg::SUM_MAX : acc[15:0];
        cur_phase = AT_LEAD;
        if (pkt_seen < pkt_total) begin
          rec.record_kind = rrhp_pkg::KIND_REDUNDANT;
          rec.payload_type = hold_type;
          rec.timestamp_offset = hold_offset;
          rec.block_start = start;
          rec.block_length = {6'b0, len};
          produced = 1'b1;
          return;
        end
      end
      default: ;
    endcase
    // Packet ended inside the headers
    if (pkt_seen >= pkt_total) begin
      rec = '0;
      rec.record_kind = rrhp_pkg::KIND_PRIMARY;
      rec.block_start = red_sum;
      rec.header_bytes = hdr_count;
      rec.length_error = 1'b1;
      cur_phase = AT_DONE;
      produced = 1'b1;
    end
  endfunction

  function automatic string describe(input rrhp_pkg::out_t r);
    return $sformatf("kind=%0d type=%0d offset=%0d start=%0d len=%0d hdr=%0d err=%0d",
                     r.record_kind, r.payload_type, r.timestamp_offset, r.block_start,
                     r.block_length, r.header_bytes, r.length_error);
  endfunction

  // Append one byte to the packet under construction
  function automatic void add_byte(input logic [7:0] v);
    pkt_bytes = {pkt_bytes, v};
  endfunction

  // Append one 4-byte redundant header to the packet under construction
  function automatic void add_header(input logic [6:0] pt, input logic [13:0] ofs,
                                     input logic [9:0] len);
    add_byte({1'b1, pt});
    add_byte(ofs[13:6]);
    add_byte({ofs[5:0], len[9:8]});
    add_byte(len[7:0]);
  endfunction

  // Offer one word after a random gap, hold it until accepted, then predict
  task automatic send_byte(input rrhp_pkg::in_t w);
    int gap;
    bit parsed;
    bit produced;
    rrhp_pkg::out_t rec;
    gap = idle_on ? int'($urandom_range(0, 13)) : 0;
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_valid <= 1'b1;
    byte_item <= w;
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
    parse_byte(w, parsed, produced, rec);
    if (parsed) bytes_parsed++;
    if (produced) pending_records = {pending_records, rec};
    bytes_sent++;
    @(negedge clk);
  endtask

  // Send the built packet; only its first word carries the length
  task automatic send_packet(input logic [15:0] plen);
    rrhp_pkg::in_t w;
    for (int i = 0; i < pkt_bytes.size(); i++) begin
      w.data_byte = pkt_bytes[i];
      w.first_byte = (i == 0);
      w.packet_length = (i == 0) ? plen : 16'($urandom_range(0, 65535));
      send_byte(w);
    end
    pkt_bytes.delete();
  endtask

  // Drop valid and wait until every expected record has come back
  task automatic wait_drained();
    byte_valid <= 1'b0;
    do @(negedge clk); while (pending_records.size() != 0);
  endtask

  task automatic test_before_packet();
    rrhp_pkg::in_t w;
    w.data_byte = 8'h80;
    w.first_byte = 1'b0;
    w.packet_length = 16'hFFFF;
    send_byte(w);
    w.data_byte = 8'h00;
    send_byte(w);
  endtask

  task automatic test_zero_length();
    add_byte(8'h00);
    add_byte(8'hFF);
    send_packet(16'd0);
  endtask

  task automatic test_primary_only();
    add_byte(8'h7F);
    send_packet(16'd1);
    // Trailing payload past the headers is dropped
    add_byte(8'h00);
    add_byte(8'hFF);
    send_packet(16'hFFFF);
  endtask

  task automatic test_redundant_chain();
    add_header(7'h7F, 14'h3FFF, 10'h3FF);
    add_header(7'h00, 14'h0000, 10'h000);
    add_byte(8'h55);
    send_packet(16'd9 + 16'd1023 + 16'd5);
  endtask

  task automatic test_short_packet();
    // Primary size goes negative
    add_header(7'h05, 14'd100, 10'h3FF);
    add_byte(8'h01);
    send_packet(16'd20);
  endtask

  task automatic test_truncated();
    // Packet ends on the second offset byte, then exactly on the length byte
    add_byte(8'h80);
    add_byte(8'h01);
    add_byte(8'h02);
    send_packet(16'd3);
    add_header(7'h2A, 14'h1555, 10'h2AA);
    send_packet(16'd4);
  endtask

  task automatic test_restart();
    // New packet starts in the middle of a header
    add_byte(8'hC3);
    add_byte(8'h3C);
    send_packet(16'd50);
    add_byte(8'h22);
    send_packet(16'd2);
  endtask

  task automatic test_backpressure();
    // Stall the receiver while a long chain with a saturating sum streams in
    idle_on = 1'b0;
    hold_request = 400;
    repeat (70) add_header(7'($urandom_range(0, 127)), 14'($urandom_range(0, 16383)), 10'h3FF);
    add_byte(8'h7F);
    send_packet(16'hFFFF);
    wait_drained();
    idle_on = 1'b1;
  endtask

  task automatic test_random_packets();
    int n_red;
    int hdr_total;
    int sum;
    int choice;
    int plen;
    logic [9:0] len;
    rrhp_pkg::in_t w;
    while (bytes_sent < 1650) begin
      idle_on = ($urandom_range(0, 3) != 0);
      choice = $urandom_range(0, 9);
      if (choice == 9) begin
        // Noise: random words with stray packet starts
        repeat ($urandom_range(1, 12)) begin
          w.data_byte = 8'($urandom_range(0, 255));
          w.first_byte = ($urandom_range(0, 5) == 0);
          w.packet_length = $urandom_range(0, 1) ? 16'($urandom_range(0, 24))
                                                 : 16'($urandom_range(0, 65535));
          send_byte(w);
        end
      end else begin
        n_red = $urandom_range(0, 4);
        sum = 0;
        repeat (n_red) begin
          case ($urandom_range(0, 7))
            0: len = 10'h000;
            1: len = 10'h3FF;
            default: len = 10'($urandom_range(0, 1023));
          endcase
          add_header(7'($urandom_range(0, 127)), 14'($urandom_range(0, 16383)), len);
          sum += len;
        end
        add_byte({1'b0, 7'($urandom_range(0, 127))});
        hdr_total = 4 * n_red + 1;
        // Pick a length that is truncated, too short, or well formed
        if (choice == 7) begin
          plen = $urandom_range(1, hdr_total);
        end else if (choice == 8 && sum > 0) begin
          plen = $urandom_range(hdr_total, hdr_total + sum - 1);
        end else begin
          case ($urandom_range(0, 3))
            0: plen = hdr_total + sum;
            1: plen = hdr_total + sum + $urandom_range(1, 20);
            2: plen = hdr_total + sum + $urandom_range(0, 2000);
            default: plen = $urandom_range(hdr_total + sum, 65535);
          endcase
        end
        repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(0, 255)));
        send_packet(16'(plen));
      end
    end
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: random hold-off per record, plus a long stall on request
  initial begin
    int gap;
    while (rst) @(negedge clk);
    forever begin
      if (hold_request > 0) begin
        rec_ready <= 1'b0;
        repeat (hold_request) @(negedge clk);
        hold_request = 0;
      end
      gap = idle_on ? int'($urandom_range(0, 13)) : 0;
      if (gap > 0) begin
        rec_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      rec_ready <= 1'b1;
      do @(posedge clk); while (!rec_valid && hold_request == 0);
      @(negedge clk);
    end
  end

  // Check each accepted record against the oldest expectation
  always @(posedge clk) begin
    rrhp_pkg::out_t want;
    if (!rst && rec_valid && rec_ready) begin
      if (pending_records.size() == 0) begin
        if (fault_count < 10) $display("unexpected record: %s", describe(rec_item));
        fault_count++;
      end else begin
        want = pending_records.pop_front();
        if (rec_item.record_kind !== want.record_kind ||
            rec_item.payload_type !== want.payload_type ||
            rec_item.timestamp_offset !== want.timestamp_offset ||
            rec_item.block_start !== want.block_start ||
            rec_item.block_length !== want.block_length ||
            rec_item.header_bytes !== want.header_bytes ||
            rec_item.length_error !== want.length_error) begin
          if (fault_count < 10) begin
            $display("record mismatch at %0t", $realtime);
            $display("  expected %s", describe(want));
            $display("  actual   %s", describe(rec_item));
          end
          fault_count++;
        end
        if (want.record_kind == rrhp_pkg::KIND_PRIMARY) primary_seen++;
        else redundant_seen++;
        if (want.length_error) error_seen++;
      end
    end
  end

  // Watchdog
  initial begin
    #4ms;
    $display("TEST FAILED");
    $finish;
  end

  // Test sequence
  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_before_packet();
    test_zero_length();
    test_primary_only();
    test_redundant_chain();
    test_short_packet();
    test_truncated();
    test_restart();
    wait_drained();
    test_backpressure();
    test_random_packets();
    wait_drained();
    repeat (16) @(posedge clk);
    fault_count += pending_records.size();
    $display("Sent %0d words, %0d of them header bytes; checked %0d redundant and %0d primary",
             bytes_sent, bytes_parsed, redundant_seen, primary_seen);
    $display("records, %0d flagged short, including a long receiver stall.", error_seen);
    if (fault_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
